@@ sv/abrb_pkg.sv @@
package abrb_pkg;

    localparam int IDX_W      = 23;
    localparam int TS_W       = 22;
    localparam int DIM_W      = 12;
    localparam int POS_W      = 13;
    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 22;

    // register map
    localparam logic [REG_IDX_W-1:0] REG_TEXTURE_START = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TEXTURE_WIDTH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AREA_WIDTH    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_AREA_HEIGHT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_POS_X         = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_POS_Y         = 3'd7;

    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic [7:0] tex_blue;
        logic [7:0] tex_green;
        logic [7:0] tex_red;
        logic [7:0] tex_alpha;
        logic [7:0] dst_blue;
        logic [7:0] dst_green;
        logic [7:0] dst_red;
    } pixel_t;

    typedef struct packed {
        logic [7:0]       out_blue;
        logic [7:0]       out_green;
        logic [7:0]       out_red;
        logic [IDX_W-1:0] screen_index;
        logic [IDX_W-1:0] texture_index;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [TS_W-1:0]         texture_start;
        logic [DIM_W-1:0]        texture_width;
        logic [DIM_W-1:0]        area_width;
        logic [DIM_W-1:0]        area_height;
        logic [DIM_W-1:0]        screen_width;
        logic [DIM_W-1:0]        screen_height;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } cfg_t;

    // per-pixel position class, decided in the front
    typedef struct packed {
        logic first;
        logic row_end;
        logic last;
    } flags_t;

    localparam int PIXEL_W = $bits(pixel_t);
    localparam int FLAGS_W = $bits(flags_t);

endpackage

@@ sv/alpha_blend_rect_blitter_core.sv @@
// Alpha-blending rectangle blitter, BGRA texture over a BGR screen.
// Input channel (push/full): one item per pixel of the rectangle in raster
// order, the texture BGRA pixel and the current screen BGR pixel. An item is
// taken at a clock edge with push high and full low.
// Result channel (empty/pop): one item per input item, in order: blended BGR,
// screen index, texture index and a last flag on the rectangle's final pixel.
// Config port: wr_en/reg_index/reg_data; the user must write it only while
// the block is idle; the block itself does not enforce it.
// Throughput: one item per cycle, sustained while the receiver pops, with a
// 4-entry queue between the position front end and the blend/index back end.
// An item passes the queue write, the multiply stage and the result register.
// If the receiver stalls, the result register holds, the multiply stage and
// the queue fill up, then full rises; no item is dropped.
// Reset: the queue and stages empty, row/column counters zero, registers at
// their defaults (sizes 1, start and positions 0).
module alpha_blend_rect_blitter_core
    import abrb_pkg::*;
#(
    parameter int MAX_DIM     = 2048,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  reg_index,
    input  logic [REG_DATA_W-1:0] reg_data,
    input  logic                  push,
    output logic                  full,
    input  pixel_t                pixel,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int QW    = CNT_W + FLAGS_W + PIXEL_W;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;

    logic             q_wr;
    logic             q_rd;
    logic             q_avail;
    flags_t           f_flags;
    logic [CNT_W-1:0] f_col;
    logic [QW-1:0]    q_wdata;
    logic [QW-1:0]    q_rdata;

    // register writes take effect on the next cycle
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_TEXTURE_START: cfg_next.texture_start = reg_data[TS_W-1:0];
                REG_TEXTURE_WIDTH: cfg_next.texture_width = reg_data[DIM_W-1:0];
                REG_AREA_WIDTH:    cfg_next.area_width    = reg_data[DIM_W-1:0];
                REG_AREA_HEIGHT:   cfg_next.area_height   = reg_data[DIM_W-1:0];
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = reg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = reg_data[DIM_W-1:0];
                REG_POS_X:         cfg_next.pos_x         = $signed(reg_data[POS_W-1:0]);
                REG_POS_Y:         cfg_next.pos_y         = $signed(reg_data[POS_W-1:0]);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.texture_start <= '0;
            cfg_reg.texture_width <= DIM_W'(1);
            cfg_reg.area_width    <= DIM_W'(1);
            cfg_reg.area_height   <= DIM_W'(1);
            cfg_reg.screen_width  <= DIM_W'(1);
            cfg_reg.screen_height <= DIM_W'(1);
            cfg_reg.pos_x         <= '0;
            cfg_reg.pos_y         <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: raster position and pixel class
    abrb_front #(
        .MAX_DIM (MAX_DIM),
        .CNT_W   (CNT_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .q_full (full),
        .q_wr   (q_wr),
        .flags  (f_flags),
        .col    (f_col)
    );

    assign q_wdata = {f_col, f_flags, pixel};

    abrb_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wdata),
        .full    (full),
        .rd      (q_rd),
        .rd_data (q_rdata),
        .avail   (q_avail)
    );

    // back: blend and screen/texture indices
    abrb_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_avail (q_avail),
        .q_pixel (q_rdata[PIXEL_W-1:0]),
        .q_flags (q_rdata[PIXEL_W+FLAGS_W-1:PIXEL_W]),
        .q_col   (q_rdata[QW-1:PIXEL_W+FLAGS_W]),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

@@ sv/abrb_front.sv @@
module abrb_front
    import abrb_pkg::*;
#(
    parameter int MAX_DIM = 2048,
    parameter int CNT_W   = $clog2(MAX_DIM)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             push,
    input  logic             q_full,
    output logic             q_wr,
    output flags_t           flags,
    output logic [CNT_W-1:0] col
);

    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;
    logic [CNT_W-1:0] lim_w;
    logic [CNT_W-1:0] lim_h;

    // last column / row index, area size clamped to 1..MAX_DIM
    always_comb
    begin
        if (cfg.area_width == '0)
        begin
            lim_w = '0;
        end
        else if (32'(cfg.area_width) > 32'(MAX_DIM))
        begin
            lim_w = CNT_W'(MAX_DIM - 1);
        end
        else
        begin
            lim_w = CNT_W'(cfg.area_width - 1'b1);
        end

        if (cfg.area_height == '0)
        begin
            lim_h = '0;
        end
        else if (32'(cfg.area_height) > 32'(MAX_DIM))
        begin
            lim_h = CNT_W'(MAX_DIM - 1);
        end
        else
        begin
            lim_h = CNT_W'(cfg.area_height - 1'b1);
        end
    end

    assign q_wr          = push && !q_full;
    assign col           = col_reg;
    assign flags.first   = (col_reg == '0) && (row_reg == '0);
    assign flags.row_end = (col_reg >= lim_w);
    assign flags.last    = flags.row_end && (row_reg >= lim_h);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_wr)
        begin
            if (flags.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (flags.row_end)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ sv/abrb_queue.sv @@
module abrb_queue
    import abrb_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd,
    output logic [W-1:0] rd_data,
    output logic         avail
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign avail   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    ap_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    ap_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("queue count did not grow on write");

    ap_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (rd && !wr) |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("queue count did not drop on read");
`endif

endmodule

@@ sv/abrb_back.sv @@
module abrb_back
    import abrb_pkg::*;
#(
    parameter int CNT_W = 11
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             q_avail,
    input  pixel_t           q_pixel,
    input  flags_t           q_flags,
    input  logic [CNT_W-1:0] q_col,
    output logic             q_rd,
    output logic             empty,
    input  logic             pop,
    output result_t          result
);

    function automatic logic signed [17:0] blend_prod(logic [7:0] s, logic [7:0] d,
                                                       logic [7:0] a);
        logic signed [8:0]  diff;
        logic signed [17:0] a_ext;
        logic signed [17:0] d_ext;
        diff  = $signed({1'b0, s}) - $signed({1'b0, d});
        a_ext = $signed({10'd0, a});
        d_ext = $signed({{9{diff[8]}}, diff});
        return a_ext * d_ext;
    endfunction

    function automatic logic [7:0] blend_fin(logic [7:0] s, logic [7:0] d, logic [7:0] a,
                                             logic signed [17:0] p);
        logic signed [17:0] q;
        q = p >>> 8;
        if (a == ALPHA_CLEAR)
        begin
            return d;
        end
        else if (a == ALPHA_OPAQUE)
        begin
            return s;
        end
        return d + q[7:0];
    endfunction

    // stage 1: products
    logic               s1_v_reg;
    pixel_t             s1_pix_reg;
    flags_t             s1_flags_reg;
    logic [CNT_W-1:0]   s1_col_reg;
    logic signed [17:0] s1_pb_reg;
    logic signed [17:0] s1_pg_reg;
    logic signed [17:0] s1_pr_reg;
    logic [DIM_W-1:0]   s1_sx_reg;
    logic [2*DIM_W-1:0] s1_yoff_reg;

    // stage 2: result register
    logic               out_v_reg;
    result_t            out_reg;

    logic [IDX_W-1:0]   sbase_reg;
    logic [IDX_W-1:0]   tbase_reg;
    logic [IDX_W-1:0]   cur_sbase;
    logic [IDX_W-1:0]   cur_tbase;
    logic [IDX_W-1:0]   col_ext;
    logic [DIM_W-1:0]   sx;
    logic [DIM_W-1:0]   sy;
    logic               s2_load;
    logic               s1_ready;

    assign s2_load  = s1_v_reg && (!out_v_reg || pop);
    assign s1_ready = !s1_v_reg || s2_load;
    assign q_rd     = q_avail && s1_ready;
    assign empty    = !out_v_reg;
    assign result   = out_reg;

    // start position clamped to 0..screen size
    always_comb
    begin
        if (cfg.pos_x[POS_W-1])
        begin
            sx = '0;
        end
        else if (cfg.pos_x[DIM_W-1:0] > cfg.screen_width)
        begin
            sx = cfg.screen_width;
        end
        else
        begin
            sx = cfg.pos_x[DIM_W-1:0];
        end

        if (cfg.pos_y[POS_W-1])
        begin
            sy = '0;
        end
        else if (cfg.pos_y[DIM_W-1:0] > cfg.screen_height)
        begin
            sy = cfg.screen_height;
        end
        else
        begin
            sy = cfg.pos_y[DIM_W-1:0];
        end
    end

    always_comb
    begin
        col_ext   = {{(IDX_W - CNT_W){1'b0}}, s1_col_reg};
        cur_sbase = s1_flags_reg.first
                  ? IDX_W'({{(IDX_W - DIM_W){1'b0}}, s1_sx_reg} + s1_yoff_reg[IDX_W-1:0])
                  : sbase_reg;
        cur_tbase = s1_flags_reg.first ? {1'b0, cfg.texture_start} : tbase_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            s1_pix_reg   <= q_pixel;
            s1_flags_reg <= q_flags;
            s1_col_reg   <= q_col;
            s1_pb_reg    <= blend_prod(q_pixel.tex_blue, q_pixel.dst_blue, q_pixel.tex_alpha);
            s1_pg_reg    <= blend_prod(q_pixel.tex_green, q_pixel.dst_green,
                                       q_pixel.tex_alpha);
            s1_pr_reg    <= blend_prod(q_pixel.tex_red, q_pixel.dst_red, q_pixel.tex_alpha);
            s1_sx_reg    <= sx;
            s1_yoff_reg  <= sy * cfg.screen_width;
        end
        if (s2_load)
        begin
            out_reg.out_blue      <= blend_fin(s1_pix_reg.tex_blue, s1_pix_reg.dst_blue,
                                               s1_pix_reg.tex_alpha, s1_pb_reg);
            out_reg.out_green     <= blend_fin(s1_pix_reg.tex_green, s1_pix_reg.dst_green,
                                               s1_pix_reg.tex_alpha, s1_pg_reg);
            out_reg.out_red       <= blend_fin(s1_pix_reg.tex_red, s1_pix_reg.dst_red,
                                               s1_pix_reg.tex_alpha, s1_pr_reg);
            out_reg.screen_index  <= cur_sbase + col_ext;
            out_reg.texture_index <= cur_tbase + col_ext;
            out_reg.last          <= s1_flags_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            sbase_reg <= '0;
            tbase_reg <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_v_reg <= q_avail;
            end
            if (s2_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_v_reg <= 1'b0;
            end
            if (s2_load)
            begin
                if (s1_flags_reg.row_end && !s1_flags_reg.last)
                begin
                    sbase_reg <= cur_sbase + {{(IDX_W - DIM_W){1'b0}}, cfg.screen_width};
                    tbase_reg <= cur_tbase + {{(IDX_W - DIM_W){1'b0}}, cfg.texture_width};
                end
                else if (s1_flags_reg.first)
                begin
                    sbase_reg <= cur_sbase;
                    tbase_reg <= cur_tbase;
                end
            end
        end
    end

endmodule
